// ===== src/acp_pkg.sv =====
package acp_pkg;

    localparam logic [7:0] CH_TILDE     = 8'h7E;
    localparam logic [7:0] CH_AT        = 8'h40;
    localparam logic [7:0] CH_HASH      = 8'h23;
    localparam logic [7:0] CH_CARET     = 8'h5E;
    localparam logic [7:0] CH_AMP       = 8'h26;
    localparam logic [7:0] CH_BANG      = 8'h21;
    localparam logic [7:0] CH_QUERY     = 8'h3F;
    localparam logic [7:0] CH_SEMICOLON = 8'h3B;
    localparam logic [7:0] CH_COMMA     = 8'h2C;
    localparam logic [7:0] CH_ZERO      = 8'h30;

    typedef struct packed {
        logic [7:0]  action_char;
        logic [7:0]  command_char;
        logic [7:0]  key_number;
        logic [15:0] value_number;
        logic [7:0]  delimiter_char;
        logic        has_value;
    } result_t;

    function automatic logic is_start(input logic [7:0] b);
        is_start = b inside {CH_TILDE, CH_AT, CH_HASH, CH_CARET, CH_AMP};
    endfunction

    function automatic logic is_delim(input logic [7:0] b);
        is_delim = b inside {CH_BANG, CH_QUERY, CH_SEMICOLON};
    endfunction

endpackage

// ===== src/acp_in_if.sv =====
interface acp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;

    modport source (output valid, output in_byte, input ready);
    modport sink (input valid, input in_byte, output ready);
endinterface

// ===== src/acp_out_if.sv =====
interface acp_out_if;
    logic        valid;
    logic        ready;
    logic [7:0]  action_char;
    logic [7:0]  command_char;
    logic [7:0]  key_number;
    logic [15:0] value_number;
    logic [7:0]  delimiter_char;
    logic        has_value;

    modport source (
        output valid, output action_char, output command_char, output key_number,
        output value_number, output delimiter_char, output has_value, input ready
    );
    modport sink (
        input valid, input action_char, input command_char, input key_number,
        input value_number, input delimiter_char, input has_value, output ready
    );
endinterface

// ===== src/acp_parse.sv =====
module acp_parse
    import acp_pkg::*;
#(
    parameter int MESSAGE_LIMIT = 19
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       accept,
    input  logic [7:0] in_byte,
    output logic       res_valid,
    output result_t    res
);

    localparam int CW = $clog2(MESSAGE_LIMIT + 1);

    logic          receiving_reg, receiving_next;
    logic [CW-1:0] count_reg, count_next;
    logic [7:0]    action_reg, action_next;
    logic [7:0]    command_reg, command_next;
    logic [7:0]    key_all_reg, key_all_next;
    logic [7:0]    key_pre_reg, key_pre_next;
    logic [15:0]   value_reg, value_next;
    logic          comma_seen_reg, comma_seen_next;
    logic          comma_last_reg, comma_last_next;

    logic [CW-1:0] count_inc;
    logic [7:0]    d8;
    logic [15:0]   d16;
    logic          first_comma;
    logic          sep;

    assign count_inc   = count_reg + CW'(1);
    assign d8          = in_byte - CH_ZERO;
    assign d16         = {8'd0, in_byte} - {8'd0, CH_ZERO};
    assign first_comma = !comma_seen_reg && (in_byte == CH_COMMA);
    assign sep         = comma_seen_reg && !comma_last_reg;

    always_comb
    begin
        receiving_next  = receiving_reg;
        count_next      = count_reg;
        action_next     = action_reg;
        command_next    = command_reg;
        key_all_next    = key_all_reg;
        key_pre_next    = key_pre_reg;
        value_next      = value_reg;
        comma_seen_next = comma_seen_reg;
        comma_last_next = comma_last_reg;
        res_valid       = 1'b0;

        res.action_char    = action_reg;
        res.command_char   = command_reg;
        res.key_number     = sep ? key_pre_reg : key_all_reg;
        res.value_number   = sep ? value_reg : 16'd0;
        res.delimiter_char = in_byte;
        res.has_value      = sep;

        if (accept)
        begin
            if (!receiving_reg)
            begin
                if (is_start(in_byte))
                begin
                    receiving_next = 1'b1;
                    action_next    = in_byte;
                    count_next     = CW'(1);
                end
            end
            else if (is_delim(in_byte))
            begin
                res_valid       = (count_inc >= CW'(3));
                receiving_next  = 1'b0;
                count_next      = '0;
                key_all_next    = '0;
                value_next      = '0;
                comma_seen_next = 1'b0;
                comma_last_next = 1'b0;
            end
            else
            begin
                if (count_reg == CW'(1))
                begin
                    command_next = in_byte;
                end
                else
                begin
                    if (first_comma)
                    begin
                        key_pre_next = key_all_reg;
                    end
                    else if (comma_seen_reg)
                    begin
                        value_next = {value_reg[12:0], 3'b000} + {value_reg[14:0], 1'b0} + d16;
                    end
                    key_all_next    = {key_all_reg[4:0], 3'b000} + {key_all_reg[6:0], 1'b0} + d8;
                    comma_seen_next = comma_seen_reg || first_comma;
                    comma_last_next = first_comma;
                end

                // overflow: drop the message without a result
                if (count_inc >= CW'(MESSAGE_LIMIT))
                begin
                    receiving_next  = 1'b0;
                    count_next      = '0;
                    key_all_next    = '0;
                    value_next      = '0;
                    comma_seen_next = 1'b0;
                    comma_last_next = 1'b0;
                end
                else
                begin
                    count_next = count_inc;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            receiving_reg  <= 1'b0;
            count_reg      <= '0;
            action_reg     <= '0;
            command_reg    <= '0;
            key_all_reg    <= '0;
            key_pre_reg    <= '0;
            value_reg      <= '0;
            comma_seen_reg <= 1'b0;
            comma_last_reg <= 1'b0;
        end
        else
        begin
            receiving_reg  <= receiving_next;
            count_reg      <= count_next;
            action_reg     <= action_next;
            command_reg    <= command_next;
            key_all_reg    <= key_all_next;
            key_pre_reg    <= key_pre_next;
            value_reg      <= value_next;
            comma_seen_reg <= comma_seen_next;
            comma_last_reg <= comma_last_next;
        end
    end

`ifndef SYNTH
    a_idle_count: assert property (@(posedge clk) disable iff (!rst_n)
        !receiving_reg |-> (count_reg == '0) && !comma_seen_reg)
        else $error("idle with message state left over");
    a_recv_count: assert property (@(posedge clk) disable iff (!rst_n)
        receiving_reg |-> (count_reg >= CW'(1)) && (count_reg < CW'(MESSAGE_LIMIT)))
        else $error("byte count out of range while receiving");
    a_res_on_accept: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> accept && receiving_reg && is_delim(in_byte))
        else $error("result without a delimiter transfer");
`endif

endmodule

// ===== src/acp_out_reg.sv =====
module acp_out_reg
    import acp_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    load,
    input  result_t load_data,
    input  logic    out_ready,
    output logic    out_valid,
    output logic    take_ok,
    output result_t out_data
);

    logic    valid_reg, valid_next;
    result_t data_reg;

    // the register frees up in the same cycle that the sink takes it
    assign take_ok   = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= load_data;
        end
    end

`ifndef SYNTH
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        load |-> (!valid_reg || out_ready))
        else $error("pending result overwritten");
    a_load_shows: assert property (@(posedge clk) disable iff (!rst_n)
        load |=> valid_reg)
        else $error("loaded result not presented");
`endif

endmodule

// ===== src/ascii_command_message_parser.sv =====
// channel   | dir | payload                                    | transfer when
// ----------+-----+--------------------------------------------+---------------------------
// in_ch     | in  | in_byte (8)                                | valid && ready
// out_ch    | out | action_char, command_char, key_number (8), | valid && ready
//           |     | value_number (16), delimiter_char, has_value|
//
// one byte a cycle while in_ch.ready is high: the parser state updates on each input
// transfer, one short step of add and compare, and the result lands in the output register
// a result appears in the cycle after its delimiter byte is taken
// rst_n is asynchronous, active low, and returns the parser to idle
// in_ch.ready is low only while a result sits unclaimed and out_ch.ready is low
module ascii_command_message_parser
    import acp_pkg::*;
#(
    parameter int MESSAGE_LIMIT = 19
) (
    input  logic      clk,
    input  logic      rst_n,
    acp_in_if.sink    in_ch,
    acp_out_if.source out_ch
);

    logic    accept;
    logic    res_valid;
    logic    take_ok;
    result_t res;
    result_t out_data;

    // input is taken whenever the output register can hold a new result
    assign in_ch.ready = take_ok;
    assign accept      = in_ch.valid && take_ok;

    // running accumulators for action, command, key and value
    acp_parse #(
        .MESSAGE_LIMIT(MESSAGE_LIMIT)
    ) u_parse (
        .clk      (clk),
        .rst_n    (rst_n),
        .accept   (accept),
        .in_byte  (in_ch.in_byte),
        .res_valid(res_valid),
        .res      (res)
    );

    // result register parting the two sides
    acp_out_reg u_out (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (res_valid),
        .load_data(res),
        .out_ready(out_ch.ready),
        .out_valid(out_ch.valid),
        .take_ok  (take_ok),
        .out_data (out_data)
    );

    assign out_ch.action_char    = out_data.action_char;
    assign out_ch.command_char   = out_data.command_char;
    assign out_ch.key_number     = out_data.key_number;
    assign out_ch.value_number   = out_data.value_number;
    assign out_ch.delimiter_char = out_data.delimiter_char;
    assign out_ch.has_value      = out_data.has_value;

endmodule
